// ===== rtl/pprv_pkg.sv =====
// Shared types and constants for the video-chip register port.
// Used by pprv_ctrl, pprv_datapath and ppu_register_port_vram.
`default_nettype none
package pprv_pkg;

    // Operation codes carried in tuser
    localparam logic [2:0] OP_CPU_READ    = 3'd0;
    localparam logic [2:0] OP_CPU_WRITE   = 3'd1;
    localparam logic [2:0] OP_PAL_QUERY   = 3'd2;
    localparam logic [2:0] OP_SPR_QUERY   = 3'd3;
    localparam logic [2:0] OP_STATUS_LOAD = 3'd4;

    // CPU register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Mirroring modes
    localparam logic [1:0] MIR_SINGLE     = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIR_FOUR       = 2'd3;

    // Fixed store geometry
    localparam int PAT_AW   = 13;           // 8 KB pattern store
    localparam int SPR_RW   = 6;            // 64 rows of 4 sprite bytes
    localparam int PAL_RW   = 3;            // 8 rows of 4 palette bytes
    localparam logic [PAT_AW-1:0] CLR_LAST = '1;
    localparam logic [PAT_AW-1:0] SPR_ROWS = 13'd64;
    localparam logic [PAT_AW-1:0] PAL_ROWS = 13'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_en;     // memory clearing sweep
        logic rd_en;        // word accepted, issue memory reads
        logic exec;         // commit the word
    } pprv_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic out_valid;
    } pprv_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ppu_register_port_vram.sv =====
// Video-chip register port with internal pattern, nametable, sprite and palette stores.
// A word is accepted in the idle state, which issues the synchronous store reads, and is
// committed in the execute state, which writes the stores and registers the result word.
// A held result word stalls the commit and with it acceptance of the next word.
// Reset: asynchronous, active low; then a clearing sweep of the stores
// (one pattern address a cycle) during which no word is accepted.
`default_nettype none
module ppu_register_port_vram
    import pprv_pkg::*;
#(
    parameter int NAMETABLE_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,       // mirroring_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,    // reg_index[2:0], write_data[10:3], table_index[16:11]
    input  wire logic [2:0]  s_axis_tuser,    // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata     // data0..data3[31:0], nmi_enabled[32],
                                              // rendering_enabled[33], scroll_x_pending[41:34],
                                              // scroll_y_pending[49:42], nametable_select[51:50]
);

    pprv_cmd_t  cmd;
    pprv_stat_t stat;
    logic [7:0] d0, d1, d2, d3, sx, sy;
    logic       nmi, rend;
    logic [1:0] nts;
    logic       unused_pad;

    pprv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pprv_datapath #(
        .NAMETABLE_BYTES (NAMETABLE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_axis_tuser),
        .in_ridx   (s_axis_tdata[2:0]),
        .in_wd     (s_axis_tdata[10:3]),
        .in_ti     (s_axis_tdata[16:11]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_d0    (d0),
        .out_d1    (d1),
        .out_d2    (d2),
        .out_d3    (d3),
        .out_nmi   (nmi),
        .out_rend  (rend),
        .out_sx    (sx),
        .out_sy    (sy),
        .out_nts   (nts)
    );

    assign m_axis_tdata = {4'h0, nts, sy, sx, rend, nmi, d3, d2, d1, d0};
    assign unused_pad   = ^s_axis_tdata[23:17];

`ifndef SYNTH
    // no word taken while the stores are being cleared
    assert property (@(posedge clk) disable iff (!rst_n) cmd.clear_en |-> !s_axis_tready)
        else $error("word accepted during clearing sweep");

    // one word in flight: after acceptance the port stays closed until the commit
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted before commit");

    // a commit never overwrites a result still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!stat.out_valid || m_axis_tready))
        else $error("result word overwritten");
`endif

endmodule
`default_nettype wire

// ===== rtl/pprv_ctrl.sv =====
// Control state machine: clearing sweep after reset, accept, commit.
// Depends on pprv_pkg.
`default_nettype none
module pprv_ctrl
    import pprv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       out_ready,
    input  wire pprv_stat_t stat,
    output pprv_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (stat.clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_EXEC;
            ST_EXEC:  if (!stat.out_valid || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // commands
    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.clear_en = (state_reg == ST_CLEAR);
    assign cmd.rd_en    = (state_reg == ST_IDLE) && in_valid;
    assign cmd.exec     = (state_reg == ST_EXEC) && (!stat.out_valid || out_ready);

endmodule
`default_nettype wire

// ===== rtl/pprv_datapath.sv =====
// Register file, video memories and output word register.
// Depends on pprv_pkg; driven by pprv_ctrl commands.
`default_nettype none
module pprv_datapath
    import pprv_pkg::*;
#(
    parameter int NAMETABLE_BYTES = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pprv_cmd_t  cmd,
    output pprv_stat_t      stat,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic [2:0] in_op,
    input  wire logic [2:0] in_ridx,
    input  wire logic [7:0] in_wd,
    input  wire logic [5:0] in_ti,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      out_d0,
    output logic [7:0]      out_d1,
    output logic [7:0]      out_d2,
    output logic [7:0]      out_d3,
    output logic            out_nmi,
    output logic            out_rend,
    output logic [7:0]      out_sx,
    output logic [7:0]      out_sy,
    output logic [1:0]      out_nts
);

    localparam int NT_AW = $clog2(NAMETABLE_BYTES);
    localparam logic [11:0] NT_MASK = 12'(NAMETABLE_BYTES - 1);
    localparam logic [13:0] NT_DEPTH = 14'(NAMETABLE_BYTES);

    // control and state registers
    logic [7:0]  ctrl_reg, ctrl_next, mask_reg, mask_next, status_reg, status_next;
    logic [7:0]  spr_addr_reg, spr_addr_next, rbuf_reg, rbuf_next;
    logic [7:0]  pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic [15:0] vaddr_reg, vaddr_next;
    logic        toggle_reg, toggle_next;
    logic [1:0]  mirror_reg;
    logic [PAT_AW-1:0] clr_cnt_reg;
    logic        out_valid_reg;

    // latched word
    logic [2:0] op_reg, ridx_reg;
    logic [7:0] wd_reg;

    // output payload
    logic [7:0] d0_reg, d1_reg, d2_reg, d3_reg;
    logic [7:0] d0_next, d1_next, d2_next, d3_next;

    // memories
    logic [7:0]  pat_mem [0:(1<<PAT_AW)-1];
    logic [7:0]  nt_mem  [0:NAMETABLE_BYTES-1];
    logic [31:0] spr_mem [0:(1<<SPR_RW)-1];
    logic [31:0] pal_mem [0:(1<<PAL_RW)-1];
    logic [7:0]  pat_rd, nt_rd;
    logic [31:0] spr_rd, pal_rd_a, pal_rd_0;

    // address decode of the video address
    logic [13:0] va;
    logic        in_pat, in_pal;
    logic [11:0] nt_slot;
    logic [NT_AW-1:0] nt_addr;
    logic [4:0]  pal_idx;
    logic [SPR_RW-1:0] spr_row_rd;
    logic [PAL_RW-1:0] pal_row_rd;
    logic [7:0]  load_byte;
    logic        wr_data, wr_oam;

    assign va     = vaddr_reg[13:0];
    assign in_pat = !va[13];
    assign in_pal = (va[13:8] == 6'h3F);

    always_comb
    begin
        unique case (mirror_reg)
            MIR_SINGLE:     nt_slot = {2'b00, va[9:0]};
            MIR_HORIZONTAL: nt_slot = {1'b0, va[11], va[9:0]};
            MIR_VERTICAL:   nt_slot = {1'b0, va[10:0]};
            MIR_FOUR:       nt_slot = va[11:0];
            default:        nt_slot = va[11:0];
        endcase
    end
    assign nt_addr = NT_AW'(nt_slot & NT_MASK);

    // upper palette backdrops alias the lower ones
    assign pal_idx = (va[4] && (va[1:0] == 2'b00)) ? {1'b0, va[3:0]} : va[4:0];

    assign spr_row_rd = (in_op == OP_SPR_QUERY) ? in_ti : spr_addr_reg[7:2];
    assign pal_row_rd = (in_op == OP_PAL_QUERY) ? in_ti[2:0] : pal_idx[4:2];

    function automatic logic [31:0] merge_byte(input logic [31:0] row, input logic [1:0] lane,
                                               input logic [7:0] b);
        logic [31:0] r;
        r = row;
        r[lane*8 +: 8] = b;
        return r;
    endfunction

    assign wr_data = cmd.exec && (op_reg == OP_CPU_WRITE) && (ridx_reg == REG_DATA);
    assign wr_oam  = cmd.exec && (op_reg == OP_CPU_WRITE) && (ridx_reg == REG_OAM_DATA);

    // pattern store
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            pat_rd <= pat_mem[va[PAT_AW-1:0]];
        if (cmd.clear_en)
            pat_mem[clr_cnt_reg] <= 8'h00;
        else if (wr_data && in_pat)
            pat_mem[va[PAT_AW-1:0]] <= wd_reg;
    end

    // nametable store
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            nt_rd <= nt_mem[nt_addr];
        if (cmd.clear_en)
        begin
            if ({1'b0, clr_cnt_reg} < NT_DEPTH)
                nt_mem[clr_cnt_reg[NT_AW-1:0]] <= 8'h00;
        end
        else if (wr_data && !in_pat && !in_pal)
            nt_mem[nt_addr] <= wd_reg;
    end

    // sprite store, four bytes a row
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            spr_rd <= spr_mem[spr_row_rd];
        if (cmd.clear_en)
        begin
            if (clr_cnt_reg < SPR_ROWS)
                spr_mem[clr_cnt_reg[SPR_RW-1:0]] <= 32'hFFFF_FFFF;
        end
        else if (wr_oam)
            spr_mem[spr_addr_reg[7:2]] <= merge_byte(spr_rd, spr_addr_reg[1:0], wd_reg);
    end

    // palette store, second port fixed on the backdrop row
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            pal_rd_a <= pal_mem[pal_row_rd];
            pal_rd_0 <= pal_mem[0];
        end
        if (cmd.clear_en)
        begin
            if (clr_cnt_reg < PAL_ROWS)
                pal_mem[clr_cnt_reg[PAL_RW-1:0]] <= 32'h0;
        end
        else if (wr_data && in_pal)
            pal_mem[pal_idx[4:2]] <= merge_byte(pal_rd_a, pal_idx[1:0], wd_reg);
    end

    always_comb
    begin
        if (in_pat)
            load_byte = pat_rd;
        else if (!in_pal)
            load_byte = nt_rd;
        else
            load_byte = pal_rd_a[pal_idx[1:0]*8 +: 8];
    end

    // register update for the committed word
    always_comb
    begin
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        spr_addr_next = spr_addr_reg;
        rbuf_next     = rbuf_reg;
        pend_x_next   = pend_x_reg;
        pend_y_next   = pend_y_reg;
        vaddr_next    = vaddr_reg;
        toggle_next   = toggle_reg;
        d0_next = 8'h00;
        d1_next = 8'h00;
        d2_next = 8'h00;
        d3_next = 8'h00;
        unique case (op_reg)
            OP_CPU_READ:
            begin
                unique case (ridx_reg)
                    REG_STATUS:
                    begin
                        d0_next        = status_reg;
                        status_next[7] = 1'b0;
                        toggle_next    = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        d0_next       = spr_rd[spr_addr_reg[1:0]*8 +: 8];
                        spr_addr_next = spr_addr_reg + 8'd1;
                    end
                    REG_DATA:
                    begin
                        d0_next    = in_pal ? load_byte : rbuf_reg;
                        rbuf_next  = load_byte;
                        vaddr_next = vaddr_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            OP_CPU_WRITE:
            begin
                unique case (ridx_reg)
                    REG_CTRL:     ctrl_next = wd_reg;
                    REG_MASK:     mask_next = wd_reg;
                    REG_OAM_ADDR: spr_addr_next = wd_reg;
                    REG_OAM_DATA: spr_addr_next = spr_addr_reg + 8'd1;
                    REG_SCROLL:
                    begin
                        if (!toggle_reg)
                            pend_x_next = wd_reg;
                        else
                            pend_y_next = wd_reg;
                        toggle_next = !toggle_reg;
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_reg)
                            vaddr_next = {2'b00, wd_reg[5:0], vaddr_reg[7:0]};
                        else
                        begin
                            vaddr_next  = {vaddr_reg[15:8], wd_reg};
                            pend_x_next = vaddr_reg[15:8];
                            pend_y_next = wd_reg;
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_DATA: vaddr_next = vaddr_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
                    default: ;
                endcase
            end
            OP_PAL_QUERY:
            begin
                d0_next = pal_rd_0[7:0];
                d1_next = pal_rd_a[15:8];
                d2_next = pal_rd_a[23:16];
                d3_next = pal_rd_a[31:24];
            end
            OP_SPR_QUERY:
            begin
                d0_next = spr_rd[7:0];
                d1_next = spr_rd[15:8];
                d2_next = spr_rd[23:16];
                d3_next = spr_rd[31:24];
            end
            OP_STATUS_LOAD: status_next = wd_reg;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            spr_addr_reg  <= '0;
            rbuf_reg      <= '0;
            pend_x_reg    <= '0;
            pend_y_reg    <= '0;
            vaddr_reg     <= '0;
            toggle_reg    <= 1'b0;
            mirror_reg    <= MIR_VERTICAL;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mirror_reg <= cfg_wdata;
            if (cmd.clear_en)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.exec)
            begin
                ctrl_reg     <= ctrl_next;
                mask_reg     <= mask_next;
                status_reg   <= status_next;
                spr_addr_reg <= spr_addr_next;
                rbuf_reg     <= rbuf_next;
                pend_x_reg   <= pend_x_next;
                pend_y_reg   <= pend_y_next;
                vaddr_reg    <= vaddr_next;
                toggle_reg   <= toggle_next;
            end
            if (cmd.exec)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // word and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            op_reg   <= in_op;
            ridx_reg <= in_ridx;
            wd_reg   <= in_wd;
        end
        if (cmd.exec)
        begin
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            d3_reg <= d3_next;
        end
    end

    assign stat.clear_done = (clr_cnt_reg == CLR_LAST);
    assign stat.out_valid  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_d0    = d0_reg;
    assign out_d1    = d1_reg;
    assign out_d2    = d2_reg;
    assign out_d3    = d3_reg;
    assign out_nmi   = ctrl_reg[7];
    assign out_rend  = mask_reg[3] | mask_reg[4];
    assign out_sx    = pend_x_reg;
    assign out_sy    = pend_y_reg;
    assign out_nts   = ctrl_reg[1:0];

endmodule
`default_nettype wire

// ===== bench/ppu_register_port_vram_tb.sv =====
// Self-checking bench for the video-chip register port: drives register traffic,
// predicts every result word and compares it field by field.
// Depends on pprv_pkg and ppu_register_port_vram.
`timescale 1ns / 1ps
`default_nettype none
module ppu_register_port_vram_tb;
    import pprv_pkg::*;

    localparam int NT_BYTES   = 4096;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        logic [1:0] nt_sel;
        logic [7:0] scroll_y;
        logic [7:0] scroll_x;
        logic       render_en;
        logic       nmi_en;
        logic [7:0] d3;
        logic [7:0] d2;
        logic [7:0] d1;
        logic [7:0] d0;
    } port_result_t;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] reg_no;
        logic [7:0] wdata;
        logic [5:0] tindex;
    } port_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    ppu_register_port_vram dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the port state
    logic [1:0]  mir_mode;
    logic [7:0]  ctrl_q, mask_q, status_q, oam_addr_q, rd_buf_q;
    logic [15:0] vaddr_q;
    logic        toggle_q;
    logic [7:0]  px_q, py_q;
    logic [1:0]  base_q;
    logic [7:0]  nt_mem  [NT_BYTES];
    logic [7:0]  spr_mem [256];
    logic [7:0]  pal_mem [32];
    logic [7:0]  pat_mem [8192];

    port_result_t result_q[$];
    int  errors;
    int  words_sent;
    int  results_seen;
    int  idle_cycles;
    bit  sending_done;
    bit  hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int nt_slot(input logic [13:0] a);
        int r;
        case (mir_mode)
            MIR_SINGLE:     r = a % 'h400;
            MIR_HORIZONTAL: r = ((a / 2) & 'h400) | (a % 'h400);
            MIR_VERTICAL:   r = a % 'h800;
            default:        r = (a - 'h2000) & 'hFFF;
        endcase
        return r & (NT_BYTES - 1);
    endfunction

    function automatic int pal_slot(input logic [13:0] a);
        return ((a & 'h13) == 'h10) ? (a & 'h0F) : (a & 'h1F);
    endfunction

    function automatic logic [7:0] vram_peek(input logic [13:0] a);
        if (a < 14'h2000) return pat_mem[a[12:0]];
        if (a < 14'h3F00) return nt_mem[nt_slot(a)];
        return pal_mem[pal_slot(a)];
    endfunction

    function automatic void vram_poke(input logic [13:0] a, input logic [7:0] v);
        if (a < 14'h2000) pat_mem[a[12:0]] = v;
        else if (a < 14'h3F00) nt_mem[nt_slot(a)] = v;
        else pal_mem[pal_slot(a)] = v;
    endfunction

    task automatic shadow_reset();
        mir_mode = MIR_VERTICAL;
        ctrl_q = 0; mask_q = 0; status_q = 0; oam_addr_q = 0; rd_buf_q = 0;
        vaddr_q = 0; toggle_q = 0; px_q = 0; py_q = 0; base_q = 0;
        foreach (nt_mem[i]) nt_mem[i] = 8'h00;
        foreach (spr_mem[i]) spr_mem[i] = 8'hFF;
        foreach (pal_mem[i]) pal_mem[i] = 8'h00;
        foreach (pat_mem[i]) pat_mem[i] = 8'h00;
    endtask

    // Apply one word to the shadow state and return the word the port should answer
    function automatic port_result_t predict_port(input port_word_t w);
        port_result_t r;
        logic [13:0]  a;
        logic [7:0]   b;
        r = '0;
        case (w.op)
            OP_CPU_READ:
                case (w.reg_no)
                    REG_STATUS:
                    begin
                        r.d0 = status_q;
                        status_q[7] = 1'b0;
                        toggle_q = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        r.d0 = spr_mem[oam_addr_q];
                        oam_addr_q++;
                    end
                    REG_DATA:
                    begin
                        a = vaddr_q[13:0];
                        if (a < 14'h3F00)
                        begin
                            r.d0 = rd_buf_q;
                            rd_buf_q = vram_peek(a);
                        end
                        else
                        begin
                            rd_buf_q = vram_peek(a);
                            r.d0 = rd_buf_q;
                        end
                        vaddr_q += ctrl_q[2] ? 16'd32 : 16'd1;
                    end
                    default: ;
                endcase
            OP_CPU_WRITE:
                case (w.reg_no)
                    REG_CTRL:
                    begin
                        ctrl_q = w.wdata;
                        base_q = w.wdata[1:0];
                    end
                    REG_MASK:     mask_q = w.wdata;
                    REG_OAM_ADDR: oam_addr_q = w.wdata;
                    REG_OAM_DATA:
                    begin
                        spr_mem[oam_addr_q] = w.wdata;
                        oam_addr_q++;
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle_q) px_q = w.wdata;
                        else py_q = w.wdata;
                        toggle_q = ~toggle_q;
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_q)
                            vaddr_q = {2'b00, w.wdata[5:0], vaddr_q[7:0]};
                        else
                        begin
                            vaddr_q[7:0] = w.wdata;
                            px_q = vaddr_q[15:8];
                            py_q = vaddr_q[7:0];
                        end
                        toggle_q = ~toggle_q;
                    end
                    REG_DATA:
                    begin
                        vram_poke(vaddr_q[13:0], w.wdata);
                        vaddr_q += ctrl_q[2] ? 16'd32 : 16'd1;
                    end
                    default: ;
                endcase
            OP_PAL_QUERY:
            begin
                b = 8'({w.tindex[2:0], 2'b00});
                r.d0 = pal_mem[0];
                r.d1 = pal_mem[b + 1];
                r.d2 = pal_mem[b + 2];
                r.d3 = pal_mem[b + 3];
            end
            OP_SPR_QUERY:
            begin
                b = {w.tindex, 2'b00};
                r.d0 = spr_mem[b];
                r.d1 = spr_mem[b + 1];
                r.d2 = spr_mem[b + 2];
                r.d3 = spr_mem[b + 3];
            end
            OP_STATUS_LOAD: status_q = w.wdata;
            default: ;
        endcase
        r.nmi_en    = ctrl_q[7];
        r.render_en = |mask_q[4:3];
        r.scroll_x  = px_q;
        r.scroll_y  = py_q;
        r.nt_sel    = base_q;
        return r;
    endfunction

    // Offer one word after a random gap; wait for acceptance
    task automatic send_word(input port_word_t w);
        @(negedge clk);
        repeat ($urandom_range(0, 10) * ($urandom_range(0, 3) != 0)) @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, w.tindex, w.wdata, w.reg_no};
        s_axis_tuser  <= w.op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        result_q.push_back(predict_port(w));
        words_sent++;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic port_word_t mk(input logic [2:0] op, input logic [2:0] rg,
                                      input logic [7:0] wd, input logic [5:0] ti);
        port_word_t w;
        w.op = op; w.reg_no = rg; w.wdata = wd; w.tindex = ti;
        return w;
    endfunction

    // Random word, mostly well-formed address/data sequences
    task automatic send_random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // set the video address: toggle reset, high then low byte
            send_word(mk(OP_CPU_READ, REG_STATUS, 8'h00, 6'd0));
            send_word(mk(OP_CPU_WRITE, REG_ADDR,
                         ($urandom_range(0, 3) == 0) ? 8'h3F : 8'($urandom), 6'd0));
            send_word(mk(OP_CPU_WRITE, REG_ADDR, 8'($urandom), 6'd0));
        end
        else if (pick < 35)
            send_word(mk(OP_CPU_WRITE, REG_DATA, 8'($urandom), 6'($urandom)));
        else if (pick < 55)
            send_word(mk(OP_CPU_READ, REG_DATA, 8'($urandom), 6'($urandom)));
        else if (pick < 65)
            send_word(mk(3'($urandom_range(OP_PAL_QUERY, OP_SPR_QUERY)), 3'($urandom),
                         8'($urandom), 6'($urandom)));
        else
            send_word(mk(3'($urandom), 3'($urandom), 8'($urandom), 6'($urandom)));
    endtask

    // Directed table: expected d0 typed in only where obvious, else checked by predictor
    typedef struct {
        port_word_t w;
        bit         has_exp;
        logic [7:0] exp_d0;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{'{OP_CPU_READ,    REG_OAM_DATA, 8'h00, 6'd0 }, 1'b1, 8'hFF},
        '{'{OP_CPU_READ,    REG_STATUS,   8'h00, 6'd0 }, 1'b1, 8'h00},
        '{'{OP_STATUS_LOAD, REG_CTRL,     8'hFF, 6'd0 }, 1'b1, 8'h00},
        '{'{OP_CPU_READ,    REG_STATUS,   8'h00, 6'd0 }, 1'b1, 8'hFF},
        '{'{OP_CPU_READ,    REG_STATUS,   8'h00, 6'd0 }, 1'b1, 8'h7F},
        '{'{OP_CPU_WRITE,   REG_CTRL,     8'hFF, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_MASK,     8'h18, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_SCROLL,   8'hAA, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_SCROLL,   8'h55, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'hFF, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h10, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_DATA,     8'h3C, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_CTRL,     8'h00, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h3F, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h00, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_READ,    REG_DATA,     8'h00, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_PAL_QUERY,   REG_CTRL,     8'h00, 6'd63}, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_OAM_ADDR, 8'hFF, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_OAM_DATA, 8'h81, 6'd0 }, 1'b0, 8'h00},
        '{'{OP_SPR_QUERY,   REG_CTRL,     8'h00, 6'd63}, 1'b0, 8'h00},
        '{'{OP_CPU_READ,    REG_CTRL,     8'hFF, 6'd0 }, 1'b1, 8'h00},
        '{'{3'd7,           REG_DATA,     8'hFF, 6'd63}, 1'b1, 8'h00},
        '{'{3'd5,           REG_DATA,     8'h00, 6'd0 }, 1'b1, 8'h00}
    };

    logic [7:0] dir_exp_q[$];
    bit         dir_has_q[$];

    // Result side: random stalls, one long hold-off, field checks
    initial
    begin
        port_result_t got, want;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            got = port_result_t'(m_axis_tdata[51:0]);
            results_seen++;
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %h", $time, got);
            end
            else
            begin
                want = result_q.pop_front();
                if (dir_has_q.size() > 0)
                begin
                    if (dir_has_q.pop_front() && dir_exp_q[0] !== got.d0)
                    begin
                        errors++;
                        $display("%0t: table d0 expected %h actual %h",
                                 $time, dir_exp_q[0], got.d0);
                    end
                    void'(dir_exp_q.pop_front());
                end
                if (got.d0 !== want.d0 || got.d1 !== want.d1 || got.d2 !== want.d2 ||
                    got.d3 !== want.d3)
                begin
                    errors++;
                    $display("%0t: data expected %h %h %h %h actual %h %h %h %h", $time,
                             want.d0, want.d1, want.d2, want.d3,
                             got.d0, got.d1, got.d2, got.d3);
                end
                if (got.nmi_en !== want.nmi_en || got.render_en !== want.render_en ||
                    got.nt_sel !== want.nt_sel)
                begin
                    errors++;
                    $display("%0t: flags expected nmi %b rend %b nt %0d actual %b %b %0d",
                             $time, want.nmi_en, want.render_en, want.nt_sel,
                             got.nmi_en, got.render_en, got.nt_sel);
                end
                if (got.scroll_x !== want.scroll_x || got.scroll_y !== want.scroll_y)
                begin
                    errors++;
                    $display("%0t: scroll expected %h/%h actual %h/%h", $time,
                             want.scroll_x, want.scroll_y, got.scroll_x, got.scroll_y);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
                $display("** ppu_register_port_vram: FAILED **");
                $finish;
            end
        end
    end

    // Wait for all results, then settle before a mirroring change
    task automatic drain();
        while (result_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mirroring(input logic [1:0] mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mir_mode = mode;
    endtask

    // Stimulus
    initial
    begin
        logic [1:0] modes[4];
        modes = '{MIR_SINGLE, MIR_FOUR, MIR_HORIZONTAL, MIR_VERTICAL};
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        sending_done = 0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        shadow_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at reset mirroring
        foreach (dir_rows[i])
        begin
            dir_has_q.push_back(dir_rows[i].has_exp);
            dir_exp_q.push_back(dir_rows[i].exp_d0);
            send_word(dir_rows[i].w);
        end
        drain();

        // random phases through every mirroring mode, one with a long output stall
        foreach (modes[m])
        begin
            write_mirroring(modes[m]);
            if (m == 1)
                hold_off = 1'b1;
            for (int n = 0; n < 385; n++)
                send_random_word();
            drain();
        end
        sending_done = 1;
        repeat (20) @(posedge clk);

        $display("Sent %0d words across all four mirroring modes, %0d results checked.",
                 words_sent, results_seen);
        if (errors == 0 && result_q.size() == 0)
            $display("** ppu_register_port_vram: PASSED **");
        else
            $display("** ppu_register_port_vram: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
